// ----- hw/rtl/bpt_pkg.sv -----
// bpt_pkg: types, sizes and codes shared by the bounded pair table.
// No dependencies; compiled first.
package bpt_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 8;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [1:0]               op_t;
  typedef logic [1:0]               status_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_DUP   = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic  add_en;
    logic  rem_en;
    cnt_t  count;
    idx_t  idx;
    data_t key;
    data_t value;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/bpt_if.sv -----
// bpt_in_if / bpt_out_if: valid/ready channels for requests and results.
// Depends on bpt_pkg.
interface bpt_in_if;
  import bpt_pkg::*;
  logic  valid;
  logic  ready;
  op_t   op;
  data_t key;
  data_t value;
  idx_t  index;
  modport source (output valid, op, key, value, index, input ready);
  modport sink   (input valid, op, key, value, index, output ready);
endinterface

interface bpt_out_if;
  import bpt_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  data_t   key_out;
  data_t   value_out;
  count_t  count;
  modport source (output valid, status, key_out, value_out, count, input ready);
  modport sink   (input valid, status, key_out, value_out, count, output ready);
endinterface

// ----- hw/rtl/bounded_pair_table_top.sv -----
// bounded_pair_table_top: packed key/value table built as a row of bpt_cell.
// Depends on bpt_pkg, bpt_if and bpt_cell.
//
// The table holds up to CAPACITY (16) pairs in insertion order. On a request,
// all cells compare against the incoming pair, and a remove shifts the later
// entries down, in the same cycle. The result is held in an output register
// and appears in the cycle after the request is taken; a new request is taken
// every cycle while results are drained. Entries need no clearing after
// reset; only the fill count, the duplicate setting and the output valid
// are reset. Write allow_duplicates only while no request is outstanding.
module bounded_pair_table_top (
  input  logic           clk,
  input  logic           rst_n,
  bpt_in_if.sink         in_if,
  bpt_out_if.source      out_if,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import bpt_pkg::*;

  cnt_t      fill_count_r, fill_count_nxt;
  logic      allow_dup_r;
  logic      out_valid_r;
  status_t   out_status_r, out_status_nxt;
  data_t     out_key_r, out_key_nxt;
  data_t     out_value_r, out_value_nxt;
  count_t    out_count_r;

  cell_cmd_t cmd;
  data_t     cell_key   [CAPACITY];
  data_t     cell_value [CAPACITY];
  logic      [CAPACITY-1:0] match;

  logic      accept;
  logic      dup_hit;
  logic      is_full;
  logic      in_range;
  data_t     rd_key, rd_value;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign dup_hit  = !allow_dup_r && (|match);
  assign is_full  = fill_count_r >= CNT_W'(CAPACITY);
  assign in_range = in_if.index < IDX_W'(fill_count_r);

  // read port: select the indexed cell
  always_comb begin
    rd_key   = '0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_if.index == IDX_W'(i)) begin
        rd_key   = rd_key | cell_key[i];
        rd_value = rd_value | cell_value[i];
      end
    end
  end

  always_comb begin
    cmd.add_en     = 1'b0;
    cmd.rem_en     = 1'b0;
    cmd.count      = fill_count_r;
    cmd.idx        = in_if.index;
    cmd.key        = in_if.key;
    cmd.value      = in_if.value;
    fill_count_nxt = fill_count_r;
    out_status_nxt = ST_OK;
    out_key_nxt    = '0;
    out_value_nxt  = '0;
    case (in_if.op)
      OP_ADD: begin
        if (dup_hit) begin
          out_status_nxt = ST_DUP;
        end else if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          cmd.add_en     = accept;
          fill_count_nxt = fill_count_r + CNT_W'(1);
        end
      end
      OP_REMOVE, OP_READ: begin
        if (!in_range) begin
          out_status_nxt = ST_RANGE;
        end else begin
          out_key_nxt   = rd_key;
          out_value_nxt = rd_value;
          if (in_if.op == OP_REMOVE) begin
            cmd.rem_en     = accept;
            fill_count_nxt = fill_count_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t nb_key, nb_value;
    if (g == CAPACITY - 1) begin : g_last
      assign nb_key   = '0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_key   = cell_key[g+1];
      assign nb_value = cell_value[g+1];
    end
    bpt_cell u_cell (
      .clk        (clk),
      .cell_idx   (CNT_W'(g)),
      .cmd        (cmd),
      .nb_key     (nb_key),
      .nb_value   (nb_value),
      .cell_key   (cell_key[g]),
      .cell_value (cell_value[g]),
      .match      (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      allow_dup_r  <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        allow_dup_r <= cfg_wdata;
      end
      if (accept) begin
        fill_count_r <= fill_count_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= COUNT_W'(fill_count_nxt);
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.key_out   = out_key_r;
  assign out_if.value_out = out_value_r;
  assign out_if.count     = out_count_r;

endmodule

// ----- hw/rtl/bpt_cell.sv -----
// bpt_cell: one table entry. Loads an appended pair, takes its upper neighbor's
// pair on a remove, and flags an exact pair match. Depends on bpt_pkg.
module bpt_cell (
  input  logic              clk,
  input  bpt_pkg::cnt_t      cell_idx,
  input  bpt_pkg::cell_cmd_t cmd,
  input  bpt_pkg::data_t     nb_key,
  input  bpt_pkg::data_t     nb_value,
  output bpt_pkg::data_t     cell_key,
  output bpt_pkg::data_t     cell_value,
  output logic               match
);
  import bpt_pkg::*;

  data_t key_r, key_nxt;
  data_t value_r, value_nxt;

  logic [CNT_W:0] idx_plus1;
  logic           occupied;
  logic           load_new;
  logic           shift_in;

  assign idx_plus1 = {1'b0, cell_idx} + {{CNT_W{1'b0}}, 1'b1};
  assign occupied  = cell_idx < cmd.count;
  assign load_new  = cmd.add_en && (cell_idx == cmd.count);
  // on remove, entries at or above the hole move down one place
  assign shift_in  = cmd.rem_en && (IDX_W'(cell_idx) >= cmd.idx)
                     && (idx_plus1 < {1'b0, cmd.count});

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (load_new) begin
      key_nxt   = cmd.key;
      value_nxt = cmd.value;
    end else if (shift_in) begin
      key_nxt   = nb_key;
      value_nxt = nb_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign cell_key   = key_r;
  assign cell_value = value_r;
  assign match      = occupied && (key_r == cmd.key) && (value_r == cmd.value);

endmodule

// ----- tb/sv/bounded_pair_table_top_tb.sv -----
// bounded_pair_table_top_tb: self-checking bench for the bounded pair table.
// Depends on bpt_pkg, bpt_if and bounded_pair_table_top; predicts every result
// from its own copy of the table and checks it as it leaves the block.
module bounded_pair_table_top_tb;
  import bpt_pkg::*;

  localparam op_t OP_UNDEF   = 2'd3;
  localparam int  CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t status;
    data_t   key_out;
    data_t   value_out;
    count_t  count;
  } table_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bpt_in_if  in_ch ();
  bpt_out_if out_ch ();

  bounded_pair_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the table
  data_t pair_keys   [CAPACITY];
  data_t pair_values [CAPACITY];
  int    stored_pairs;
  bit    dup_allowed;

  table_result_t table_results_due [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic table_result_t compute_table_result(op_t op, data_t key, data_t value,
                                                         idx_t idx);
    table_result_t res;
    bit found;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ADD: begin
        found = 1'b0;
        for (int i = 0; i < stored_pairs; i++)
          if (pair_keys[i] == key && pair_values[i] == value) found = 1'b1;
        // duplicate check wins over the full check
        if (!dup_allowed && found) begin
          res.status = ST_DUP;
        end else if (stored_pairs >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pair_keys[stored_pairs]   = key;
          pair_values[stored_pairs] = value;
          stored_pairs++;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (int'(idx) >= stored_pairs) begin
          res.status = ST_RANGE;
        end else begin
          res.key_out   = pair_keys[idx];
          res.value_out = pair_values[idx];
          if (op == OP_REMOVE) begin
            for (int i = int'(idx); i + 1 < stored_pairs; i++) begin
              pair_keys[i]   = pair_keys[i + 1];
              pair_values[i] = pair_values[i + 1];
            end
            stored_pairs--;
          end
        end
      end
      default: ;
    endcase
    res.count = count_t'(stored_pairs);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0d: %0s", cycle_count, what);
    error_count++;
  endtask

  // Called at a rising edge; returns at the edge where the request is taken,
  // with valid still high so back-to-back requests need no extra step.
  task automatic send_request(op_t op, data_t key, data_t value, idx_t idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= key;
    in_ch.value <= value;
    in_ch.index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    table_results_due.insert(table_results_due.size(),
                             compute_table_result(op, key, value, idx));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (table_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_allow_duplicates(bit allow);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= allow;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dup_allowed = allow;
  endtask

  // Small pool half the time so exact pairs repeat
  function automatic data_t pick_data();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3, 4:    return data_t'($urandom_range(3));
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic test_empty_table();
    send_request(OP_READ,   '0, '0, 8'd0);
    send_request(OP_REMOVE, '0, '0, 8'd0);
    send_request(OP_READ,   '0, '0, 8'd255);
    send_request(OP_UNDEF,  32'sh7fff_ffff, 32'sh8000_0000, 8'd255);
  endtask

  task automatic test_add_read_remove();
    send_request(OP_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 8'd0);
    send_request(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 8'd0);
    send_request(OP_ADD, 32'sh0,         32'sh0,         8'd255);
    send_request(OP_ADD, -32'sd1,        -32'sd1,        8'd0);
    send_request(OP_ADD, -32'sd1,        -32'sd1,        8'd0);
    send_request(OP_READ,   '0, '0, 8'd0);
    send_request(OP_READ,   '0, '0, 8'd4);
    send_request(OP_READ,   '0, '0, 8'd5);
    send_request(OP_REMOVE, '0, '0, 8'd1);
    send_request(OP_READ,   '0, '0, 8'd1);
    send_request(OP_UNDEF,  -32'sd1, 32'sd1, 8'd0);
  endtask

  task automatic test_duplicate_rejection();
    write_allow_duplicates(1'b0);
    send_request(OP_ADD, -32'sd1, -32'sd1, 8'd0);
    send_request(OP_ADD, -32'sd1, 32'sd5, 8'd0);
    while (stored_pairs < CAPACITY)
      send_request(OP_ADD, data_t'($urandom), data_t'($urandom), idx_t'($urandom));
    // rejected as duplicate even though the table is full
    send_request(OP_ADD, pair_keys[3], pair_values[3], 8'd0);
    send_request(OP_ADD, 32'sd12345, -32'sd12345, 8'd0);
    send_request(OP_READ,   '0, '0, 8'd15);
    send_request(OP_READ,   '0, '0, 8'd16);
    send_request(OP_REMOVE, '0, '0, 8'd15);
    send_request(OP_REMOVE, '0, '0, 8'd0);
  endtask

  // Alternates between filling and draining runs so the table swings
  // between empty and full.
  task automatic run_random_traffic(int n_items, bit pause_midway);
    int   add_pct;
    int   pick;
    op_t  op;
    idx_t idx;
    add_pct = 70;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 39) add_pct = (add_pct == 70) ? 20 : 70;
      if (pause_midway && n == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 5)                 op = OP_UNDEF;
      else if (pick < 5 + add_pct)  op = OP_ADD;
      else if (pick % 2 == 0)       op = OP_REMOVE;
      else                          op = OP_READ;
      case ($urandom_range(9))
        0:       idx = idx_t'($urandom_range(255));
        1, 2:    idx = idx_t'($urandom_range(CAPACITY + 1));
        default: idx = idx_t'($urandom_range(stored_pairs));
      endcase
      send_request(op, pick_data(), pick_data(), idx);
    end
  endtask

  // Receiver: random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.key_out, out_ch.value_out, out_ch.count};
      if (table_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = table_results_due.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.key_out !== want.key_out)
          report_mismatch($sformatf("key_out %0d, want %0d", got.key_out, want.key_out));
        if (got.value_out !== want.value_out)
          report_mismatch($sformatf("value_out %0d, want %0d", got.value_out,
                                    want.value_out));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stored_pairs  = 0;
    dup_allowed   = 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 78;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_ADD;
    in_ch.key   <= '0;
    in_ch.value <= '0;
    in_ch.index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_read_remove();
    test_duplicate_rejection();
    write_allow_duplicates(1'b1);
    run_random_traffic(600, 1'b0);

    send_idle_pct = 78;
    recv_idle_pct = 34;
    write_allow_duplicates(1'b0);
    run_random_traffic(600, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_allow_duplicates(1'b1);
    run_random_traffic(250, 1'b0);
    write_allow_duplicates(1'b0);
    run_random_traffic(250, 1'b0);

    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
